[rtl/a2m_pkg.sv]
// ----------------------------------------------------------------------------
// a2m_pkg
// Shared types, constants and the crc byte update for the ax.25 to m17
// reframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package a2m_pkg;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  SYNC_BYTE  = 8'h5D;
  localparam logic [7:0]  TYPE_BYTE  = 8'h00;
  localparam logic [7:0]  PAD_BYTE   = 8'h00;
  localparam logic [4:0]  MIN_FRAME  = 5'd10;
  localparam logic [4:0]  HDR_PLUS2  = 5'd16;
  localparam logic [4:0]  COUNT_SAT  = 5'd17;
  localparam logic [5:0]  BODY_LEN   = 6'd48;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       prefix;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ax25_to_m17_reframer.sv]
// an input beat's command is registered in the command queue, its result beat in the output register
// throughput: one input beat per cycle while the queue is not full and frame bytes only pass through;
//   one result beat per cycle while res_stall is low, up to 50 beats for a closing flag
// a four-entry command queue absorbs bursts, input stalls while it is full
// reset: synchronous, clears frame tracking, queue, crc and output valid;
//   no clearing pass, input ready in the first cycle after reset
// ----------------------------------------------------------------------------
// ax25_to_m17_reframer
// Converts a flag-delimited ax.25 byte stream into m17 style frames: strips
// header and fcs, prefixes sync and type, pads to 48 bytes and appends crc.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ax25_to_m17_reframer (
  input  wire        clk,
  input  wire        rst,
  input  wire        rx_valid,
  output logic       rx_stall,
  input  wire [7:0]  rx_byte,
  output logic       res_valid,
  input  wire        res_stall,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import a2m_pkg::*;

  logic push;
  cmd_t push_cmd;
  cmd_t head;
  logic q_valid;
  logic q_full;
  logic pop;

  a2m_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .rx_stall (rx_stall),
    .push     (push),
    .push_cmd (push_cmd)
  );

  a2m_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  a2m_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire

[rtl/a2m_front.sv]
// ----------------------------------------------------------------------------
// a2m_front
// Frame tracking: flag detection, byte counting and the two-byte hold that
// strips the fcs. Emits data and close commands into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module a2m_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              rx_valid,
  input  wire [7:0]        rx_byte,
  input  wire              q_full,
  output logic             rx_stall,
  output logic             push,
  output a2m_pkg::cmd_t    push_cmd
);
  import a2m_pkg::*;

  logic       in_frame;
  logic [4:0] frame_count;
  logic [7:0] hold_bytes [2];
  logic       accept;
  logic       is_flag;

  assign rx_stall = q_full;
  assign accept   = rx_valid && !q_full;
  assign is_flag  = (rx_byte == FLAG_BYTE);

  always_comb begin
    push            = 1'b0;
    push_cmd.op     = OP_DATA;
    push_cmd.prefix = 1'b0;
    push_cmd.data   = hold_bytes[1];
    if (accept && in_frame) begin
      if (is_flag && frame_count != 5'd0) begin
        push_cmd.op     = OP_CLOSE;
        push_cmd.prefix = (frame_count <= HDR_PLUS2);
        push            = (frame_count >= MIN_FRAME);
      end else if (frame_count >= HDR_PLUS2) begin
        push_cmd.prefix = (frame_count == HDR_PLUS2);
        push            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      frame_count <= 5'd0;
    end else if (accept) begin
      if (!in_frame) begin
        if (is_flag) begin
          in_frame    <= 1'b1;
          frame_count <= 5'd0;
        end
      end else if (is_flag && frame_count != 5'd0) begin
        in_frame <= 1'b0;
      end else if (frame_count < COUNT_SAT) begin
        frame_count <= frame_count + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame && !(is_flag && frame_count != 5'd0)) begin
      hold_bytes[1] <= hold_bytes[0];
      hold_bytes[0] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/a2m_queue.sv]
// ----------------------------------------------------------------------------
// a2m_queue
// Small command queue between the frame tracker and the output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module a2m_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire a2m_pkg::cmd_t push_cmd,
  input  wire              pop,
  output a2m_pkg::cmd_t    head,
  output logic             not_empty,
  output logic             full
);
  import a2m_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (QAW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/a2m_back.sv]
// ----------------------------------------------------------------------------
// a2m_back
// Output sequencer: expands each command into body bytes, zero padding and
// the crc, one beat per cycle while the output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module a2m_back (
  input  wire              clk,
  input  wire              rst,
  input  wire a2m_pkg::cmd_t head,
  input  wire              q_valid,
  output logic             pop,
  output logic             res_valid,
  input  wire              res_stall,
  output logic [7:0]       out_byte,
  output logic             run_last
);
  import a2m_pkg::*;

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_MAIN = 4'b0100,
    PH_CRCH = 4'b1000
  } ph_t;

  ph_t         ph;
  ph_t         ph_next;
  logic [15:0] crc;
  logic [5:0]  sent;
  logic [15:0] crc_base;
  logic [5:0]  sent_base;
  logic [15:0] crc_next;
  logic [5:0]  sent_next;
  logic        step;
  logic        body;
  logic        last;
  logic        do_main;
  logic [7:0]  byte_next;

  assign step = q_valid && (!res_valid || !res_stall);

  always_comb begin
    crc_base  = crc;
    sent_base = sent;
    if (ph == PH_HEAD && head.prefix) begin
      crc_base  = CRC_INIT;
      sent_base = 6'd0;
    end
  end

  always_comb begin
    ph_next   = ph;
    byte_next = head.data;
    body      = 1'b0;
    last      = 1'b0;
    pop       = 1'b0;
    do_main   = 1'b0;
    case (ph)
      PH_HEAD: begin
        if (head.prefix) begin
          byte_next = SYNC_BYTE;
          body      = 1'b1;
          ph_next   = PH_TYPE;
        end else begin
          do_main = 1'b1;
        end
      end
      PH_TYPE: begin
        byte_next = TYPE_BYTE;
        body      = 1'b1;
        ph_next   = PH_MAIN;
      end
      PH_MAIN: begin
        do_main = 1'b1;
      end
      PH_CRCH: begin
        byte_next = crc[15:8];
        last      = 1'b1;
        pop       = step;
        ph_next   = PH_HEAD;
      end
      default: begin
        ph_next = PH_HEAD;
      end
    endcase
    if (do_main) begin
      if (head.op == OP_DATA) begin
        byte_next = head.data;
        body      = 1'b1;
        last      = 1'b1;
        pop       = step;
        ph_next   = PH_HEAD;
      end else if (sent_base < BODY_LEN) begin
        byte_next = PAD_BYTE;
        body      = 1'b1;
        ph_next   = PH_MAIN;
      end else begin
        byte_next = crc_base[7:0];
        ph_next   = PH_CRCH;
      end
    end
  end

  assign crc_next  = crc_byte(crc_base, byte_next);
  assign sent_next = (sent_base < BODY_LEN) ? sent_base + 6'd1 : sent_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= PH_HEAD;
      crc       <= CRC_INIT;
      sent      <= 6'd0;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        ph        <= ph_next;
        res_valid <= 1'b1;
        if (body) begin
          crc  <= crc_next;
          sent <= sent_next;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= byte_next;
      run_last <= last;
    end
  end

endmodule

`default_nettype wire

[rtl/a2m_checker.sv]
// ----------------------------------------------------------------------------
// a2m_checker
// Port-level checks for the reframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module a2m_checker (
  input wire       clk,
  input wire       rst,
  input wire       rx_stall,
  input wire       res_valid,
  input wire       res_stall,
  input wire [7:0] out_byte,
  input wire       run_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(out_byte) && $stable(run_last))
    else $error("result beat changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result beat right after reset");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rx_stall)
    else $error("input stalled right after reset");

endmodule

bind ax25_to_m17_reframer a2m_checker u_a2m_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_stall  (rx_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_byte  (out_byte),
  .run_last  (run_last)
);

`default_nettype wire

[test/ax25_to_m17_reframer_tb.sv]
// ----------------------------------------------------------------------------
// ax25_to_m17_reframer_tb
// Drives flag-delimited byte streams into the reframer with random gaps and
// result stalls. Each accepted rx beat is run through a behavioral tracker
// that queues the expected m17 frame beats, and every result beat is checked
// against the oldest one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ax25_to_m17_reframer_tb;

  import a2m_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 260;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } m17_beat_t;

  class m17_body_tracker;
    m17_beat_t   due[$];
    bit          rx_open;
    logic [4:0]  rx_count;
    logic [7:0]  prev_bytes[2];
    logic [15:0] body_crc;
    logic [5:0]  body_sent;
    int          errors;
    int          checked;

    function new();
      rx_open    = 1'b0;
      rx_count   = '0;
      prev_bytes = '{8'h00, 8'h00};
      body_crc   = CRC_INIT;
      body_sent  = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void add_beat(logic [7:0] d);
      m17_beat_t beat;
      beat.data = d;
      beat.last = 1'b0;
      due.insert(due.size(), beat);
    endfunction

    function void push_body(logic [7:0] b);
      body_crc = crc_step(body_crc, b);
      if (body_sent < BODY_LEN) begin
        body_sent++;
      end
      add_beat(b);
    endfunction

    function void take_rx_byte(logic [7:0] b);
      int was;
      was = due.size();
      if (!rx_open) begin
        if (b == FLAG_BYTE) begin
          rx_open   = 1'b1;
          rx_count  = '0;
          body_crc  = CRC_INIT;
          body_sent = '0;
        end
      end else if (b == FLAG_BYTE && rx_count != 0) begin
        rx_open = 1'b0;
        if (rx_count >= MIN_FRAME) begin
          if (rx_count <= HDR_PLUS2) begin
            push_body(SYNC_BYTE);
            push_body(TYPE_BYTE);
          end
          while (body_sent < BODY_LEN) begin
            push_body(PAD_BYTE);
          end
          add_beat(body_crc[7:0]);
          add_beat(body_crc[15:8]);
        end
      end else begin
        if (rx_count >= HDR_PLUS2) begin
          if (rx_count == HDR_PLUS2) begin
            push_body(SYNC_BYTE);
            push_body(TYPE_BYTE);
          end
          push_body(prev_bytes[1]);
        end
        prev_bytes[1] = prev_bytes[0];
        prev_bytes[0] = b;
        if (rx_count < COUNT_SAT) begin
          rx_count++;
        end
      end
      if (due.size() > was) begin
        due[due.size() - 1].last = 1'b1;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void check_out_byte(logic [7:0] d, logic l);
      m17_beat_t exp_beat;
      checked++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result beat %0d: out_byte %02h run_last %0b", checked, d, l);
        end
        return;
      end
      exp_beat = due.pop_front();
      if (exp_beat.data !== d || exp_beat.last !== l) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at result beat %0d: expected out_byte %02h run_last %0b, got %02h %0b",
                   checked, exp_beat.data, exp_beat.last, d, l);
        end
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       rx_valid  = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte   = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  m17_body_tracker tracker = new();

  int  rx_beats    = 0;
  int  frames_sent = 0;
  int  frame_items = 0;
  int  idle_cycles = 0;
  bit  no_gaps     = 1'b0;
  bit  paused_once = 1'b0;

  logic [7:0] corner_bytes[10] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55,
                                   8'hAA, 8'h7D, 8'h7F, 8'hFE, 8'h00};

  ax25_to_m17_reframer i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      tracker.check_out_byte(out_byte, run_last);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int  k;
    int  len;
    logic val;
    forever begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        val = 1'b0;
        len = $urandom_range(1, 30);
      end else if (k < 8) begin
        val = 1'b1;
        len = $urandom_range(1, 3);
      end else if (k < 9) begin
        val = 1'b1;
        len = $urandom_range(4, 10);
      end else begin
        val = 1'b1;
        len = $urandom_range(11, 40);
      end
      @(negedge clk);
      res_stall <= val;
      repeat (len - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (no_gaps || k < 55) begin
      return 0;
    end else if (k < 85) begin
      return $urandom_range(1, 3);
    end else if (k < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      rx_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    tracker.take_rx_byte(b);
    rx_beats++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input int len, input bit lead_flag);
    logic [7:0] b;
    send_byte(FLAG_BYTE);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && lead_flag) begin
        b = FLAG_BYTE;
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == FLAG_BYTE) b = 8'($urandom_range(0, 255));
      end
      send_byte(b);
    end
    send_byte(FLAG_BYTE);
    frames_sent++;
    frame_items += len + 2;
  endtask

  initial begin
    int k;
    int len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle noise, then a dropped frame whose first byte is a flag kept as data
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8, 1'b1);

    // minimum length frame with corner byte values
    send_byte(FLAG_BYTE);
    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);
    send_byte(FLAG_BYTE);
    frames_sent++;
    wait_drained();

    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 99);
      if (k < 65) begin
        len = $urandom_range(10, 30);
        send_frame(len, $urandom_range(0, 7) == 0);
      end else if (k < 77) begin
        len = $urandom_range(47, 70);
        send_frame(len, 1'b0);
      end else if (k < 88) begin
        len = $urandom_range(1, 9);
        send_frame(len, $urandom_range(0, 2) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)) & 8'hFD);
      end
      if (!paused_once && frame_items > RANDOM_ITEMS / 2) begin
        paused_once = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);

    $display("run covered %0d rx beats in %0d frames with random gaps and stalls",
             rx_beats, frames_sent);
    $display("%0d result beats checked, %0d mismatches", tracker.checked, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[ax25_to_m17_reframer.f]
rtl/a2m_pkg.sv
rtl/a2m_front.sv
rtl/a2m_queue.sv
rtl/a2m_back.sv
rtl/ax25_to_m17_reframer.sv
rtl/a2m_checker.sv
test/ax25_to_m17_reframer_tb.sv
